/* rtl/sqcg_pkg.sv */
// shared types, constants and register codes of the sprite quad corner generator
package sqcg_pkg;

  localparam int unsigned AngleBitsDefault = 16;

  localparam logic [30:0] SinA = 31'd1686629713;
  localparam logic [29:0] SinB = 30'd688904866;
  localparam logic [26:0] SinC = 27'd76016977;
  localparam logic [31:0] Q30One = 32'd1073741824;

  localparam logic signed [35:0] VertMax = 36'sd8388607;
  localparam logic signed [35:0] VertMin = -36'sd8388608;

  localparam logic [15:0] ScaleReset = 16'd256;
  localparam logic [16:0] UvSizeReset = 17'd65536;

  typedef enum logic [2:0] {
    RegScaleX  = 3'd0,
    RegScaleY  = 3'd1,
    RegOriginX = 3'd2,
    RegOriginY = 3'd3,
    RegUvLeft  = 3'd4,
    RegUvTop   = 3'd5,
    RegUvWidth = 3'd6,
    RegUvHeight = 3'd7
  } cfg_reg_e;

  typedef enum logic [1:0] {
    CornerTl = 2'd0,
    CornerTr = 2'd1,
    CornerBr = 2'd2,
    CornerBl = 2'd3
  } corner_e;

  typedef struct packed {
    logic en_a;
    logic en_b;
    logic en_c;
    logic en_d;
  } sine_ctl_t;

  typedef struct packed {
    logic signed [23:0] px;
    logic signed [23:0] py;
    logic signed [15:0] depth;
    logic [31:0]        color;
  } sprite_t;

endpackage

/* rtl/sqcg_sine.sv */
// four stage quarter-wave polynomial sine in Q2.30
module sqcg_sine
  import sqcg_pkg::*;
(
  input  logic               clk_i,
  input  sine_ctl_t          ctl_i,
  input  logic [22:0]        x_i,
  input  logic               neg_i,
  output logic signed [31:0] s_o
);

  logic [22:0] xa_q, xb_q, xc_q;
  logic        nega_q, negb_q, negc_q;
  logic [30:0] x2a_q, x2b_q;
  logic [29:0] innb_q;
  logic [30:0] midc_q;
  logic signed [31:0] s_q;

  logic [45:0] sq;
  logic [57:0] pb;
  logic [60:0] pc;
  logic [53:0] pd;
  logic [31:0] sv;
  logic [31:0] sc;

  always_comb begin
    sq = x_i * x_i;
    pb = x2a_q * SinC;
    pc = x2b_q * innb_q;
    pd = xc_q * midc_q;
    sv = pd[53:22];
    sc = (sv > Q30One) ? Q30One : sv;
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.en_a) begin
      xa_q   <= x_i;
      nega_q <= neg_i;
      x2a_q  <= sq[44:14];
    end
    if (ctl_i.en_b) begin
      xb_q   <= xa_q;
      negb_q <= nega_q;
      x2b_q  <= x2a_q;
      innb_q <= SinB - pb[57:30];
    end
    if (ctl_i.en_c) begin
      xc_q   <= xb_q;
      negc_q <= negb_q;
      midc_q <= SinA - pc[60:30];
    end
    if (ctl_i.en_d) begin
      s_q <= negc_q ? -$signed(sc) : $signed(sc);
    end
  end

  assign s_o = s_q;

endmodule

/* rtl/sprite_quad_corner_generator.sv */
// top level: sprite to four rotated quad corner vertices
//
//  channel  | handshake             | payload
//  ---------+-----------------------+------------------------------------------
//  in       | in_valid_i/in_ready_o | pos_x, pos_y, depth, rotation, tex size,
//           |                       | color
//  out      | out_valid_o/out_ready_i | corner, vert_x/y, depth, tex_u/v, color,
//           |                       | last
//  cfg      | cfg_we_i              | cfg_index_i, cfg_data_i
//
// one sprite per four beats, set by the single corner datapath (one beat per cycle
// while out_ready_i is high); a beat passes the sprite stages, then the corner stages
// reset clears valid bits and corner count, presets config; payload not reset
// a stall on the output holds every stage that is full; empty stages keep filling
module sprite_quad_corner_generator
  import sqcg_pkg::*;
#(
  parameter int unsigned ANGLE_BITS = AngleBitsDefault
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [2:0]         cfg_index_i,
  input  logic [16:0]        cfg_data_i,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic signed [23:0] pos_x_i,
  input  logic signed [23:0] pos_y_i,
  input  logic signed [15:0] depth_i,
  input  logic [15:0]        rotation_i,
  input  logic [12:0]        tex_width_i,
  input  logic [12:0]        tex_height_i,
  input  logic [31:0]        color_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [1:0]         corner_o,
  output logic signed [23:0] vert_x_o,
  output logic signed [23:0] vert_y_o,
  output logic signed [15:0] vert_depth_o,
  output logic [17:0]        tex_u_o,
  output logic [17:0]        tex_v_o,
  output logic [31:0]        vert_color_o,
  output logic               last_o
);

  localparam int unsigned AngDrop = 24 - ANGLE_BITS;

  // configuration
  logic [15:0] scale_x_q, scale_y_q;
  logic [16:0] origin_x_q, origin_y_q, uv_left_q, uv_top_q, uv_width_q, uv_height_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scale_x_q   <= ScaleReset;
      scale_y_q   <= ScaleReset;
      origin_x_q  <= '0;
      origin_y_q  <= '0;
      uv_left_q   <= '0;
      uv_top_q    <= '0;
      uv_width_q  <= UvSizeReset;
      uv_height_q <= UvSizeReset;
    end else if (cfg_we_i) begin
      unique case (cfg_reg_e'(cfg_index_i))
        RegScaleX:   scale_x_q   <= cfg_data_i[15:0];
        RegScaleY:   scale_y_q   <= cfg_data_i[15:0];
        RegOriginX:  origin_x_q  <= cfg_data_i;
        RegOriginY:  origin_y_q  <= cfg_data_i;
        RegUvLeft:   uv_left_q   <= cfg_data_i;
        RegUvTop:    uv_top_q    <= cfg_data_i;
        RegUvWidth:  uv_width_q  <= cfg_data_i;
        RegUvHeight: uv_height_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // stage valids and enables: sprite stages 1..6, corner stages 7..9
  logic [9:1]  v_q;
  logic [10:1] en;
  logic [1:0]  cnt_q;
  logic        emit;

  always_comb begin
    en[10] = out_ready_i;
    en[9]  = !v_q[9] || en[10];
    en[8]  = !v_q[8] || en[9];
    en[7]  = !v_q[7] || en[8];
    emit   = v_q[6] && en[7];
    en[6]  = !v_q[6] || (emit && (cnt_q == 2'd3));
    for (int k = 5; k >= 1; k--) begin
      en[k] = !v_q[k] || en[k+1];
    end
  end

  assign in_ready_o = en[1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q   <= '0;
      cnt_q <= '0;
    end else begin
      if (en[1]) v_q[1] <= in_valid_i;
      for (int k = 2; k <= 6; k++) begin
        if (en[k]) v_q[k] <= v_q[k-1];
      end
      if (en[7]) v_q[7] <= v_q[6];
      if (en[8]) v_q[8] <= v_q[7];
      if (en[9]) v_q[9] <= v_q[8];
      if (emit) cnt_q <= cnt_q + 2'd1;
    end
  end

  // sprite stages
  sprite_t     sp_q [1:6];
  logic [23:0] ang_q;
  logic [28:0] m1x_q, m1y_q;
  logic [29:0] w2_q, h2_q, w3_q, h3_q;
  logic [30:0] cx3_q, cy3_q;
  logic signed [31:0] oxl4_q, oxr4_q, oyt4_q, oyb4_q;
  logic signed [31:0] oxl5_q, oxr5_q, oyt5_q, oyb5_q;
  logic signed [31:0] oxl6_q, oxr6_q, oyt6_q, oyb6_q, sn6_q, cs6_q;

  logic [23:0] ang_in, ang_c;
  logic [22:0] xs, xc;
  logic [45:0] pw, ph;
  logic [46:0] pcx, pcy;
  logic signed [31:0] sn, cs;
  sine_ctl_t   sctl;

  always_comb begin
    ang_in = ({rotation_i, 8'h00} >> AngDrop) << AngDrop;
    ang_c  = ang_q + 24'h400000;
    xs = ang_q[22] ? (23'h400000 - {1'b0, ang_q[21:0]}) : {1'b0, ang_q[21:0]};
    xc = ang_c[22] ? (23'h400000 - {1'b0, ang_c[21:0]}) : {1'b0, ang_c[21:0]};
    pw  = m1x_q * uv_width_q;
    ph  = m1y_q * uv_height_q;
    pcx = origin_x_q * w2_q;
    pcy = origin_y_q * h2_q;
    sctl.en_a = en[2];
    sctl.en_b = en[3];
    sctl.en_c = en[4];
    sctl.en_d = en[5];
  end

  sqcg_sine u_sin (
    .clk_i (clk_i),
    .ctl_i (sctl),
    .x_i   (xs),
    .neg_i (ang_q[23]),
    .s_o   (sn)
  );

  sqcg_sine u_cos (
    .clk_i (clk_i),
    .ctl_i (sctl),
    .x_i   (xc),
    .neg_i (ang_c[23]),
    .s_o   (cs)
  );

  always_ff @(posedge clk_i) begin
    if (en[1]) begin
      sp_q[1] <= '{px: pos_x_i, py: pos_y_i, depth: depth_i, color: color_i};
      ang_q   <= ang_in;
      m1x_q   <= scale_x_q * tex_width_i;
      m1y_q   <= scale_y_q * tex_height_i;
    end
    if (en[2]) begin
      sp_q[2] <= sp_q[1];
      w2_q    <= pw[45:16];
      h2_q    <= ph[45:16];
    end
    if (en[3]) begin
      sp_q[3] <= sp_q[2];
      w3_q    <= w2_q;
      h3_q    <= h2_q;
      cx3_q   <= pcx[46:16];
      cy3_q   <= pcy[46:16];
    end
    if (en[4]) begin
      sp_q[4] <= sp_q[3];
      oxl4_q  <= -$signed({1'b0, cx3_q});
      oxr4_q  <= $signed({2'b00, w3_q}) - $signed({1'b0, cx3_q});
      oyt4_q  <= -$signed({1'b0, cy3_q});
      oyb4_q  <= $signed({2'b00, h3_q}) - $signed({1'b0, cy3_q});
    end
    if (en[5]) begin
      sp_q[5] <= sp_q[4];
      oxl5_q  <= oxl4_q;
      oxr5_q  <= oxr4_q;
      oyt5_q  <= oyt4_q;
      oyb5_q  <= oyb4_q;
    end
    if (en[6]) begin
      sp_q[6] <= sp_q[5];
      oxl6_q  <= oxl5_q;
      oxr6_q  <= oxr5_q;
      oyt6_q  <= oyt5_q;
      oyb6_q  <= oyb5_q;
      sn6_q   <= sn;
      cs6_q   <= cs;
    end
  end

  // corner stages
  corner_e            k;
  logic               left, top;
  logic signed [31:0] ox, oy;
  logic [17:0]        u_sel, v_sel;

  sprite_t            sp7_q, sp8_q;
  corner_e            k7_q, k8_q, k9_q;
  logic [17:0]        u7_q, v7_q, u8_q, v8_q, u9_q, v9_q;
  logic signed [63:0] pcx7_q, psy7_q, psx7_q, pcy7_q;
  logic signed [34:0] rx8_q, ry8_q;
  logic signed [23:0] vx9_q, vy9_q;
  logic signed [15:0] d9_q;
  logic [31:0]        c9_q;

  logic signed [64:0] sumx, sumy;
  logic signed [35:0] tx, ty;

  always_comb begin
    k     = corner_e'(cnt_q);
    left  = (k == CornerTl) || (k == CornerBl);
    top   = (k == CornerTl) || (k == CornerTr);
    ox    = left ? oxl6_q : oxr6_q;
    oy    = top ? oyt6_q : oyb6_q;
    u_sel = left ? {1'b0, uv_left_q} : ({1'b0, uv_left_q} + {1'b0, uv_width_q});
    v_sel = top ? {1'b0, uv_top_q} : ({1'b0, uv_top_q} + {1'b0, uv_height_q});
    sumx  = 65'(pcx7_q) - 65'(psy7_q) + 65'sd536870912;
    sumy  = 65'(psx7_q) + 65'(pcy7_q) + 65'sd536870912;
    tx    = 36'(sp8_q.px) + 36'(rx8_q);
    ty    = 36'(sp8_q.py) + 36'(ry8_q);
  end

  always_ff @(posedge clk_i) begin
    if (en[7]) begin
      sp7_q  <= sp_q[6];
      k7_q   <= k;
      u7_q   <= u_sel;
      v7_q   <= v_sel;
      pcx7_q <= cs6_q * ox;
      psy7_q <= sn6_q * oy;
      psx7_q <= sn6_q * ox;
      pcy7_q <= cs6_q * oy;
    end
    if (en[8]) begin
      sp8_q <= sp7_q;
      k8_q  <= k7_q;
      u8_q  <= u7_q;
      v8_q  <= v7_q;
      rx8_q <= sumx[64:30];
      ry8_q <= sumy[64:30];
    end
    if (en[9]) begin
      k9_q  <= k8_q;
      u9_q  <= u8_q;
      v9_q  <= v8_q;
      d9_q  <= sp8_q.depth;
      c9_q  <= sp8_q.color;
      vx9_q <= (tx > VertMax) ? VertMax[23:0] : (tx < VertMin) ? VertMin[23:0] : tx[23:0];
      vy9_q <= (ty > VertMax) ? VertMax[23:0] : (ty < VertMin) ? VertMin[23:0] : ty[23:0];
    end
  end

  assign out_valid_o  = v_q[9];
  assign corner_o     = k9_q;
  assign vert_x_o     = vx9_q;
  assign vert_y_o     = vy9_q;
  assign vert_depth_o = d9_q;
  assign tex_u_o      = u9_q;
  assign tex_v_o      = v9_q;
  assign vert_color_o = c9_q;
  assign last_o       = (k9_q == CornerBl);

endmodule

/* rtl/sqcg_checker.sv */
// port level checks of the sprite quad corner generator, bound to the top level
module sqcg_checker
  import sqcg_pkg::*;
(
  input logic               clk_i,
  input logic               rst_ni,
  input logic               out_valid_o,
  input logic               out_ready_i,
  input logic [1:0]         corner_o,
  input logic signed [23:0] vert_x_o,
  input logic               last_o
);

  logic [1:0] exp_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      exp_q <= '0;
    end else if (out_valid_o && out_ready_i) begin
      exp_q <= corner_o + 2'd1;
    end
  end

  // corners leave in order, four to a sprite
  a_corner_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_ready_i |-> corner_o == exp_q)
    else $error("corner out of order");

  a_last_bl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (last_o == (corner_o == CornerBl)))
    else $error("last not on bottom-left corner");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(corner_o) && $stable(vert_x_o))
    else $error("stalled beat changed");

  a_reset_idle: assert property (@(posedge clk_i) !rst_ni |-> !out_valid_o)
    else $error("output valid in reset");

endmodule

bind sprite_quad_corner_generator sqcg_checker u_sqcg_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .corner_o    (corner_o),
  .vert_x_o    (vert_x_o),
  .last_o      (last_o)
);

/* bench/sprite_quad_corner_checker.sv */
// vertex predictor and scoreboard for the sprite quad corner generator
`timescale 1ns / 100ps
module sprite_quad_corner_checker
  import sqcg_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [2:0]         cfg_index_i,
  input  logic [16:0]        cfg_data_i,
  input  logic               in_valid_i,
  input  logic               in_ready_o,
  input  logic signed [23:0] pos_x_i,
  input  logic signed [23:0] pos_y_i,
  input  logic signed [15:0] depth_i,
  input  logic [15:0]        rotation_i,
  input  logic [12:0]        tex_width_i,
  input  logic [12:0]        tex_height_i,
  input  logic [31:0]        color_i,
  input  logic               out_valid_o,
  input  logic               out_ready_i,
  input  logic [1:0]         corner_o,
  input  logic signed [23:0] vert_x_o,
  input  logic signed [23:0] vert_y_o,
  input  logic signed [15:0] vert_depth_o,
  input  logic [17:0]        tex_u_o,
  input  logic [17:0]        tex_v_o,
  input  logic [31:0]        vert_color_o,
  input  logic               last_o,
  output int                 errors_o,
  output int                 pending_o
);

  typedef struct packed {
    logic [1:0]         corner;
    logic signed [23:0] x;
    logic signed [23:0] y;
    logic signed [15:0] depth;
    logic [17:0]        u;
    logic [17:0]        v;
    logic [31:0]        color;
    logic               last;
  } vertex_t;

  vertex_t vertex_q[$];
  logic [15:0] scl_x, scl_y;
  logic [16:0] org_x, org_y, uvl, uvt, uvw, uvh;

  assign pending_o = vertex_q.size();

  function automatic longint quarter_wave(longint x);
    longint xq, x2, inner, mid, s;
    xq = x << 8;
    x2 = (xq * xq) >>> 30;
    inner = longint'(SinB) - ((x2 * longint'(SinC)) >>> 30);
    mid = longint'(SinA) - ((x2 * inner) >>> 30);
    s = (xq * mid) >>> 30;
    if (s > longint'(Q30One)) s = longint'(Q30One);
    return s;
  endfunction

  function automatic longint turn_sine(logic [23:0] ang);
    logic [1:0] q;
    longint r, s;
    q = ang[23:22];
    r = longint'(ang[21:0]);
    s = quarter_wave(q[0] ? (64'sd4194304 - r) : r);
    return q[1] ? -s : s;
  endfunction

  function automatic logic signed [23:0] clamp24(longint v);
    if (v > 64'sd8388607) return 24'sd8388607;
    if (v < -64'sd8388608) return -24'sd8388608;
    return v[23:0];
  endfunction

  function automatic longint round_q30(longint v);
    return (v + 64'sd536870912) >>> 30;
  endfunction

  task automatic predict_corners();
    longint w, h, cx, cy, sn, cs, ox, oy;
    logic [23:0] ang;
    vertex_t vt;
    w = longint'((64'(scl_x) * 64'(tex_width_i) * 64'(uvw)) >> 16);
    h = longint'((64'(scl_y) * 64'(tex_height_i) * 64'(uvh)) >> 16);
    cx = longint'((64'(org_x) * 64'(w)) >> 16);
    cy = longint'((64'(org_y) * 64'(h)) >> 16);
    ang = {rotation_i, 8'd0};
    sn = turn_sine(ang);
    cs = turn_sine(ang + 24'h400000);
    for (int k = 0; k < 4; k++) begin
      ox = (k == 1 || k == 2) ? w - cx : -cx;
      oy = (k >= 2) ? h - cy : -cy;
      vt.corner = k[1:0];
      vt.x = clamp24(longint'(pos_x_i) + round_q30(cs * ox - sn * oy));
      vt.y = clamp24(longint'(pos_y_i) + round_q30(sn * ox + cs * oy));
      vt.depth = depth_i;
      vt.u = (k == 1 || k == 2) ? 18'(uvl) + 18'(uvw) : 18'(uvl);
      vt.v = (k >= 2) ? 18'(uvt) + 18'(uvh) : 18'(uvt);
      vt.color = color_i;
      vt.last = (k == 3);
      vertex_q.push_back(vt);
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    vertex_t exp_v;
    if (!rst_ni) begin
      scl_x <= ScaleReset;
      scl_y <= ScaleReset;
      org_x <= '0;
      org_y <= '0;
      uvl <= '0;
      uvt <= '0;
      uvw <= UvSizeReset;
      uvh <= UvSizeReset;
      errors_o <= 0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_reg_e'(cfg_index_i))
          RegScaleX:   scl_x <= cfg_data_i[15:0];
          RegScaleY:   scl_y <= cfg_data_i[15:0];
          RegOriginX:  org_x <= cfg_data_i;
          RegOriginY:  org_y <= cfg_data_i;
          RegUvLeft:   uvl <= cfg_data_i;
          RegUvTop:    uvt <= cfg_data_i;
          RegUvWidth:  uvw <= cfg_data_i;
          RegUvHeight: uvh <= cfg_data_i;
          default: ;
        endcase
      end
      if (in_valid_i && in_ready_o) predict_corners();
      if (out_valid_o && out_ready_i) begin
        if (vertex_q.size() == 0) begin
          $display("%t unexpected beat: corner %0d x %0d y %0d", $time, corner_o,
                   vert_x_o, vert_y_o);
          errors_o <= errors_o + 1;
        end else begin
          exp_v = vertex_q.pop_front();
          if (exp_v != {corner_o, vert_x_o, vert_y_o, vert_depth_o, tex_u_o, tex_v_o,
                        vert_color_o, last_o}) begin
            $display("%t mismatch exp c%0d x%0d y%0d d%0d u%0d v%0d col%h l%0d", $time,
                     exp_v.corner, exp_v.x, exp_v.y, exp_v.depth, exp_v.u, exp_v.v,
                     exp_v.color, exp_v.last);
            $display("%t          got c%0d x%0d y%0d d%0d u%0d v%0d col%h l%0d", $time,
                     corner_o, vert_x_o, vert_y_o, vert_depth_o, tex_u_o, tex_v_o,
                     vert_color_o, last_o);
            errors_o <= errors_o + 1;
          end
        end
      end
    end
  end

endmodule

/* bench/tb_sprite_quad_corner_generator.sv */
// stimulus, idling phases and verdict for the sprite quad corner generator
`timescale 1ns / 100ps
module tb_sprite_quad_corner_generator;
  import sqcg_pkg::*;

  logic clk_i, rst_ni;
  logic cfg_we_i;
  logic [2:0] cfg_index_i;
  logic [16:0] cfg_data_i;
  logic in_valid_i, in_ready_o, out_valid_o, out_ready_i;
  logic signed [23:0] pos_x_i, pos_y_i, vert_x_o, vert_y_o;
  logic signed [15:0] depth_i, vert_depth_o;
  logic [15:0] rotation_i;
  logic [12:0] tex_width_i, tex_height_i;
  logic [31:0] color_i, vert_color_o;
  logic [1:0] corner_o;
  logic [17:0] tex_u_o, tex_v_o;
  logic last_o;
  int errors, pending;
  int send_idle_pct, recv_stall_pct;
  bit hold_off;

  sprite_quad_corner_generator i_dut (.*);
  sprite_quad_corner_checker i_checker (.*, .errors_o(errors), .pending_o(pending));

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  initial begin
    #20ms;
    $display("tb_sprite_quad_corner_generator NOT OK");
    $finish;
  end

  // receiver: random stalls plus one long hold-off
  initial begin
    out_ready_i = 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_off) begin
        out_ready_i <= 1'b0;
        repeat (60) @(posedge clk_i);
        hold_off = 1'b0;
      end
      out_ready_i <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // write enable stays high across back to back writes; the caller drops it
  task automatic write_reg(cfg_reg_e idx, logic [16:0] val);
    cfg_we_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
  endtask

  task automatic drain();
    while (pending != 0) @(posedge clk_i);
    repeat (12) @(posedge clk_i);
  endtask

  task automatic send_sprite(logic signed [23:0] x, logic signed [23:0] y,
                             logic signed [15:0] d, logic [15:0] rot,
                             logic [12:0] tw, logic [12:0] th, logic [31:0] col);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    pos_x_i <= x;
    pos_y_i <= y;
    depth_i <= d;
    rotation_i <= rot;
    tex_width_i <= tw;
    tex_height_i <= th;
    color_i <= col;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
  endtask

  task automatic send_random();
    logic [12:0] tw, th;
    tw = ($urandom_range(9) == 0) ? 13'($urandom_range(8191)) : 13'($urandom_range(1, 4096));
    th = ($urandom_range(9) == 0) ? 13'($urandom_range(8191)) : 13'($urandom_range(1, 4096));
    send_sprite(24'($urandom), 24'($urandom), 16'($urandom), 16'($urandom), tw, th,
                $urandom);
  endtask

  task automatic random_config(bit extreme);
    write_reg(RegScaleX, extreme ? 17'($urandom_range(1) * 65535) : 17'($urandom_range(1024)));
    write_reg(RegScaleY, extreme ? 17'($urandom_range(1) * 65535) : 17'($urandom_range(1024)));
    write_reg(RegOriginX, extreme ? 17'($urandom_range(1) * 131071) : 17'($urandom_range(65536)));
    write_reg(RegOriginY, extreme ? 17'($urandom_range(1) * 131071) : 17'($urandom_range(65536)));
    write_reg(RegUvLeft, extreme ? 17'h1ffff : 17'($urandom_range(65536)));
    write_reg(RegUvTop, extreme ? 17'h1ffff : 17'($urandom_range(65536)));
    write_reg(RegUvWidth, extreme ? 17'h1ffff : 17'($urandom_range(65536)));
    write_reg(RegUvHeight, extreme ? 17'h1ffff : 17'($urandom_range(65536)));
    cfg_we_i <= 1'b0;
  endtask

  initial begin
    logic [15:0] rots[8] = '{16'h0000, 16'h4000, 16'h8000, 16'hc000,
                              16'h2000, 16'hffff, 16'h0001, 16'h3fff};
    rst_ni = 1'b0;
    cfg_we_i = 1'b0;
    cfg_index_i = '0;
    cfg_data_i = '0;
    in_valid_i = 1'b0;
    pos_x_i = '0;
    pos_y_i = '0;
    depth_i = '0;
    rotation_i = '0;
    tex_width_i = 13'd1;
    tex_height_i = 13'd1;
    color_i = '0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    hold_off = 1'b0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: reset config, angles, extremes, saturation, degenerate quads, then edge config values
    foreach (rots[i]) send_sprite(24'sd1000, -24'sd2000, 16'sd7, rots[i], 13'd16, 13'd8,
                                  32'h12345678);
    send_sprite(24'sh7fffff, 24'sh7fffff, 16'sh7fff, 16'h2000, 13'd4096, 13'd4096, '1);
    send_sprite(-24'sh800000, -24'sh800000, -16'sh8000, 16'ha000, 13'd4096, 13'd4096, '0);
    send_sprite(24'sd0, 24'sd0, 16'sd0, 16'h1234, 13'd0, 13'd0, 32'hdeadbeef);
    send_sprite(24'sd5, 24'sd5, 16'sd1, 16'h0, 13'h1fff, 13'h1fff, 32'h0f0f0f0f);
    in_valid_i <= 1'b0;
    drain();
    write_reg(RegScaleX, 17'd0);
    write_reg(RegScaleY, 17'd65535);
    write_reg(RegOriginX, 17'd32768);
    write_reg(RegOriginY, 17'd65536);
    write_reg(RegUvLeft, 17'd131071);
    write_reg(RegUvTop, 17'd0);
    write_reg(RegUvWidth, 17'd131071);
    write_reg(RegUvHeight, 17'd0);
    cfg_we_i <= 1'b0;
    for (int i = 0; i < 4; i++) send_random();
    send_sprite(24'sh7fffff, -24'sh800000, 16'sd3, 16'h6000, 13'd4096, 13'd4096, 32'h1);
    in_valid_i <= 1'b0;
    drain();

    // random phases with changing settings, idling and receiver stalls
    for (int ph = 0; ph < 8; ph++) begin
      random_config(ph == 3 || ph == 6);
      case (ph % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 62; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 62; end
        default: begin send_idle_pct = 32; recv_stall_pct = 32; end
      endcase
      if (ph == 4) hold_off = 1'b1;
      for (int i = 0; i < 26; i++) send_random();
      in_valid_i <= 1'b0;
      drain();
    end

    if (errors == 0) begin
      $display("tb_sprite_quad_corner_generator OK");
    end else begin
      $display("tb_sprite_quad_corner_generator NOT OK");
    end
    $finish;
  end

endmodule

/* files.f */
rtl/sqcg_pkg.sv
rtl/sqcg_sine.sv
rtl/sprite_quad_corner_generator.sv
rtl/sqcg_checker.sv
bench/sprite_quad_corner_checker.sv
bench/tb_sprite_quad_corner_generator.sv
